/* rtl/core/stp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Section timing profiler package
// Shared sizes, operation and status codes, and the per-slot statistics word.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int KEY_W   = 16;
    localparam int TS_W    = 63;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 32;
    localparam int VAL_W   = 64;

    localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
    localparam logic [OP_W-1:0] OP_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_OPEN = 2'd1;
    localparam logic [STAT_W-1:0] ST_FAIL = 2'd2;

    localparam logic [VAL_W-1:0] VAL_POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct packed {
        logic [TS_W-1:0]  stamp;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] min0;
        logic [VAL_W-1:0] min1;
        logic [VAL_W-1:0] max0;
        logic [VAL_W-1:0] max1;
    } t_stats;

    localparam t_stats STATS_INIT = '{
        stamp: '0,
        count: '0,
        sum:   '0,
        min0:  VAL_POS_MAX,
        min1:  VAL_POS_MAX,
        max0:  '0,
        max1:  '0
    };

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic              free_ok;
        logic [SLOT_W-1:0] free_idx;
    } t_lookup;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
    } t_alloc;

    // last field in the lowest bits
    typedef struct packed {
        logic [VAL_W-1:0]  second_largest;
        logic [VAL_W-1:0]  largest;
        logic [VAL_W-1:0]  second_smallest;
        logic [VAL_W-1:0]  smallest;
        logic [VAL_W-1:0]  total_ticks;
        logic [CNT_W-1:0]  call_count;
        logic [VAL_W-1:0]  duration;
        logic [IDX_W-1:0]  slot_index;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

/* rtl/core/stp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Synchronous write, registered read.
// ----------------------------------------------------------------------------
module stp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/stp_key_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Section key table
// Slot keys and used bits in flops, parallel key compare, slot encoders.
// ----------------------------------------------------------------------------
module stp_key_table
    import stp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_lookup_en,
    input  t_alloc           i_alloc,
    output t_lookup          o_look
);

    logic [SLOTS-1:0] r_used;
    logic [KEY_W-1:0] r_key [SLOTS];
    logic [SLOTS-1:0] r_match;
    logic [SLOTS-1:0] r_free;
    logic [SLOTS-1:0] n_match;

    function automatic logic [SLOT_W-1:0] low_idx(input logic [SLOTS-1:0] v);
        logic [SLOTS-1:0]  iso;
        logic [SLOT_W-1:0] idx;
        iso = v & (~v + SLOTS'(1));
        idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (iso[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_match[i] = r_used[i] && (r_key[i] == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_alloc.en) begin
            r_used[i_alloc.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_alloc.en) begin
            r_key[i_alloc.idx] <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lookup_en) begin
            r_match <= n_match;
            r_free  <= ~r_used;
        end
    end

    assign o_look.hit      = |r_match;
    assign o_look.hit_idx  = low_idx(r_match);
    assign o_look.free_ok  = |r_free;
    assign o_look.free_idx = low_idx(r_free);

endmodule

/* rtl/core/stp_stat_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot statistics update
// Next statistics word of a slot for a begin or end event.
// ----------------------------------------------------------------------------
module stp_stat_update
    import stp_pkg::*;
(
    input  logic [OP_W-1:0]  i_op,
    input  logic [TS_W-1:0]  i_ts,
    input  logic [VAL_W-1:0] i_dur,
    input  t_stats           i_cur,
    output t_stats           o_next,
    output logic             o_open
);

    assign o_open = (i_cur.stamp != '0);

    always_comb begin
        o_next = i_cur;
        if (i_op == OP_BEGIN) begin
            if (!o_open) begin
                o_next.stamp = i_ts;
            end
        end else if (i_op == OP_END) begin
            o_next.stamp = '0;
            o_next.sum   = i_cur.sum + i_dur;
            if (i_cur.count != '1) begin
                o_next.count = i_cur.count + CNT_W'(1);
            end
            if ($signed(i_dur) < $signed(i_cur.min0)) begin
                o_next.min1 = i_cur.min0;
                o_next.min0 = i_dur;
            end else if ($signed(i_dur) < $signed(i_cur.min1)) begin
                o_next.min1 = i_dur;
            end
            if ($signed(i_dur) > $signed(i_cur.max0)) begin
                o_next.max1 = i_cur.max0;
                o_next.max0 = i_dur;
            end else if ($signed(i_dur) > $signed(i_cur.max1)) begin
                o_next.max1 = i_dur;
            end
        end
    end

endmodule

/* rtl/core/section_timing_profiler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Section timing profiler
// Per-section begin/end timing with count, total, two smallest and two
// largest durations, looked up by a 16-bit section key.
// ----------------------------------------------------------------------------
// One transaction is handled at a time, from acceptance to a registered
// result: key compare against the slot flops, slot encode with the
// statistics memory read, duration subtract, then update and write-back
// into the statistics memory. The input is ready again as soon as the
// result is registered, so a new transaction is taken only once the last
// one is through; the result is held in an output register until taken,
// so a stalled output delays only the write-back step. Each begin, end or
// query transaction gives exactly one result transaction. No clearing pass
// runs after reset: the slot used bits mark which memory entries are live.
module section_timing_profiler
    import stp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [79:0]  i_s_tdata,   // section_key[15:0], timestamp[78:16], pad
    input  logic [1:0]   i_s_tuser,   // operation[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [423:0] o_m_tdata    // status[1:0], slot_index[7:2],
                                      // duration[71:8], call_count[103:72],
                                      // total_ticks[167:104], smallest[231:168],
                                      // second_smallest[295:232],
                                      // largest[359:296], second_largest[423:360]
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_ENC   = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;

    localparam int SW = $bits(t_stats);

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [TS_W-1:0]   r_ts;
    logic              r_hit;
    logic              r_alloc;
    logic              r_fail;
    logic [SLOT_W-1:0] r_slot;
    t_stats            r_cur;
    logic [VAL_W-1:0]  r_dur;
    logic              r_o_valid;
    t_result           r_res;
    t_result           n_res;

    t_lookup           look;
    t_alloc            alloc;
    t_stats            next_stats;
    t_stats            src_stats;
    logic [SW-1:0]     rd_data;
    logic              slot_open;
    logic              accept;
    logic              fire;
    logic              wr_en;
    logic              n_hit;
    logic              n_alloc;
    logic              n_fail;
    logic              op_known;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign fire       = (r_state == S_UPD) && (!r_o_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_MATCH;
            S_MATCH: n_state = S_ENC;
            S_ENC:   n_state = S_CALC;
            S_CALC:  n_state = S_UPD;
            S_UPD:   if (fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_s_tuser[OP_W-1:0];
            r_key <= i_s_tdata[KEY_W-1:0];
            r_ts  <= i_s_tdata[KEY_W +: TS_W];
        end
    end

    stp_key_table u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_key),
        .i_lookup_en (r_state == S_MATCH),
        .i_alloc     (alloc),
        .o_look      (look)
    );

    // slot decision
    assign op_known = (r_op == OP_BEGIN) || (r_op == OP_END) || (r_op == OP_QUERY);
    assign n_hit    = look.hit;
    assign n_alloc  = (r_op == OP_BEGIN) && !look.hit && look.free_ok;
    assign n_fail   = !op_known || (!look.hit && ((r_op != OP_BEGIN) || !look.free_ok));

    always_ff @(posedge i_clk) begin
        if (r_state == S_ENC) begin
            r_hit   <= n_hit;
            r_alloc <= n_alloc;
            r_fail  <= n_fail;
            r_slot  <= look.hit ? look.hit_idx : look.free_idx;
        end
    end

    stp_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SW)
    ) u_stats (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (next_stats),
        .i_rd_en   (r_state == S_ENC),
        .i_rd_addr (look.hit ? look.hit_idx : look.free_idx),
        .o_rd_data (rd_data)
    );

    // fresh slot starts from the reset statistics
    assign src_stats = r_alloc ? STATS_INIT : t_stats'(rd_data);

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            r_cur <= src_stats;
            r_dur <= {1'b0, r_ts} - {1'b0, src_stats.stamp};
        end
    end

    stp_stat_update u_update (
        .i_op   (r_op),
        .i_ts   (r_ts),
        .i_dur  (r_dur),
        .i_cur  (r_cur),
        .o_next (next_stats),
        .o_open (slot_open)
    );

    assign wr_en = fire && !r_fail &&
                   ((r_op == OP_END) || ((r_op == OP_BEGIN) && !slot_open));

    assign alloc.en  = fire && r_alloc && !r_fail;
    assign alloc.idx = r_slot;

    always_comb begin
        n_res = '0;
        if (r_fail) begin
            n_res.status = ST_FAIL;
        end else begin
            n_res.status          = ((r_op == OP_BEGIN) && slot_open) ? ST_OPEN : ST_OK;
            n_res.slot_index      = IDX_W'(r_slot);
            n_res.duration        = (r_op == OP_END) ? r_dur : '0;
            n_res.call_count      = next_stats.count;
            n_res.total_ticks     = next_stats.sum;
            n_res.smallest        = next_stats.min0;
            n_res.second_smallest = next_stats.min1;
            n_res.largest         = next_stats.max0;
            n_res.second_largest  = next_stats.max1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fire) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_res;

`ifndef ASSERT_OFF
    a_no_wr_outside_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_UPD))
        else $error("statistics write outside update step");

    a_alloc_excl_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CALC) && r_alloc) |-> (!r_hit && !r_fail && (r_op == OP_BEGIN)))
        else $error("allocation on a matched key");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_res.status == ST_FAIL)) |->
            ((r_res.slot_index == '0) && (r_res.call_count == '0) &&
             (r_res.duration == '0)))
        else $error("failed lookup with nonzero fields");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MATCH))
        else $error("accepted transaction not started");
`endif

endmodule
